### hw/rtl/atz_pkg.sv
// Package: types, constants and arctangent table for the tilt-angle unit.
package atz_pkg;

  localparam int ANGLE_FRAC_BITS = 6;
  localparam int ACC_BITS        = 20;
  localparam int CORDIC_STEPS    = 24;
  localparam int STEP_W          = 5;
  localparam int CW              = 58;   // CORDIC datapath width
  localparam int ZW              = 32;   // angle accumulator width
  localparam int MW              = 34;   // mapped-axis width
  localparam int DIV_STEPS       = 35;   // divider steps per axis: load plus one per bit
  localparam int DCNT_W          = 6;

  localparam logic [ZW-1:0] DEG90  = ZW'(90  * (1 << ACC_BITS));
  localparam logic [ZW-1:0] DEG180 = ZW'(180 * (1 << ACC_BITS));
  localparam logic [ZW-1:0] DEG270 = ZW'(270 * (1 << ACC_BITS));
  localparam logic [ZW-1:0] DEG360 = ZW'(360 * (1 << ACC_BITS));

  localparam logic CFG_MIN_RAW = 1'b0;
  localparam logic CFG_MAX_RAW = 1'b1;
  localparam logic ACT_CAPTURE = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_MAPEND, ST_CINIT, ST_CITER, ST_CEND, ST_OUT
  } state_t;

  function automatic logic [ZW-1:0] atan_lut(input logic [STEP_W-1:0] i);
    logic [ZW-1:0] v;
    case (i)
      5'd0:  v = 32'd47185920;  5'd1:  v = 32'd27855475;
      5'd2:  v = 32'd14718068;  5'd3:  v = 32'd7471121;
      5'd4:  v = 32'd3750058;   5'd5:  v = 32'd1876857;
      5'd6:  v = 32'd938658;    5'd7:  v = 32'd469357;
      5'd8:  v = 32'd234682;    5'd9:  v = 32'd117342;
      5'd10: v = 32'd58671;     5'd11: v = 32'd29335;
      5'd12: v = 32'd14668;     5'd13: v = 32'd7334;
      5'd14: v = 32'd3667;      5'd15: v = 32'd1833;
      5'd16: v = 32'd917;       5'd17: v = 32'd458;
      5'd18: v = 32'd229;       5'd19: v = 32'd115;
      5'd20: v = 32'd57;        5'd21: v = 32'd29;
      5'd22: v = 32'd14;        5'd23: v = 32'd7;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### hw/rtl/accel_tilt_angle_zeroed_unit.sv
// Top level: accelerometer tilt angles with captured zero reference.
//
// Input stream (in_*): one request per three-axis sample; tuser = action
// (0 capture reference, 1 measure relative), tdata = accel_x, accel_y,
// accel_z from the low bits. Output stream (out_*): one result per request,
// tdata = angle_x, angle_y, angle_z, tuser = span_error.
// Config channel (cfg_*): index 0 min_raw, index 1 max_raw, always ready.
// Each axis is mapped by a restoring divider: a load step, 34 quotient
// bits and a step for sign and offset. Each of the three angles then goes
// through the shared CORDIC stage: 24 iterations plus one setup and one
// wrap step. A further step forms the result, and a new request is taken
// only once the last result has left the sequencer. A bad span skips the
// divider and CORDIC and goes straight to the result step.
// in_tready is high whenever the sequencer is idle; a finished result waits
// in the sequencer while the output register is still full, so a stalled
// receiver holds off the request after the next one.
// Reset (synchronous, rst_n low) restores min_raw 265, max_raw 402, clears
// the references and empties the output register.
module accel_tilt_angle_zeroed_unit import atz_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // accel_x[15:0], accel_y[31:16], accel_z[47:32]
  input  logic        in_tuser,   // action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // angle_x[15:0], angle_y[31:16], angle_z[47:32]
  output logic        out_tuser,  // span_error
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  state_t state_r, state_nxt;
  logic signed [15:0] min_r, max_r;
  logic [14:0] refx_r, refy_r, refz_r;
  logic act_r;
  logic signed [15:0] raw_r [3];
  logic signed [MW-1:0] map_r [3];
  logic [1:0] axis_r;
  logic [DCNT_W-1:0] dcnt_r;
  logic [MW-1:0] rem_r, quo_r, den_r;
  logic neg_r;
  logic signed [CW-1:0] cx_r, cy_r;
  logic signed [ZW:0] cz_r;
  logic [STEP_W-1:0] step_r;
  logic [ZW-1:0] ang_r [3];
  logic [47:0] odata_r;
  logic ouser_r, ovalid_r;

  logic span_bad;
  logic out_free;
  assign span_bad = (max_r <= min_r);
  assign out_free = !ovalid_r || out_tready;
  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == ST_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_tdata = odata_r;
  assign out_tuser = ouser_r;

  // Divider operands: |raw-lo|*180 over span
  logic signed [17:0] diff;
  logic [MW-1:0] num_abs;
  logic signed [MW-1:0] num_s;
  assign diff = 18'(raw_r[axis_r]) - 18'(min_r);
  assign num_s = MW'(diff) * MW'(180);
  assign num_abs = num_s[MW-1] ? MW'(-num_s) : MW'(num_s);

  logic [MW:0] trial;
  assign trial = {rem_r, quo_r[MW-1]} - {1'b0, den_r};

  // CORDIC pair selection: X (my,mz), Y (mx,mz), Z (my,mx)
  logic signed [MW-1:0] pa, pb;
  always_comb begin
    case (axis_r)
      2'd0: begin pa = map_r[1]; pb = map_r[2]; end
      2'd1: begin pa = map_r[0]; pb = map_r[2]; end
      default: begin pa = map_r[1]; pb = map_r[0]; end
    endcase
  end

  logic signed [CW-1:0] dx, dy;
  assign dx = cy_r >>> step_r;
  assign dy = cx_r >>> step_r;

  logic signed [ZW:0] zw;
  always_comb begin
    zw = cz_r;
    if (zw < 0) zw = zw + (ZW+1)'(DEG360);
    if (zw > $signed((ZW+1)'(DEG360))) zw = zw - (ZW+1)'(DEG360);
  end

  localparam int SH = ACC_BITS - ANGLE_FRAC_BITS;
  function automatic logic [15:0] units(input logic [ZW-1:0] a);
    logic [ZW-1:0] t;
    t = (a + ZW'(1 << (SH - 1))) >> SH;
    return t[15:0];
  endfunction

  logic [15:0] ux, uy, uz;
  assign ux = units(ang_r[0]);
  assign uy = units(ang_r[1]);
  assign uz = units(ang_r[2]);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_tvalid && in_tready) state_nxt = span_bad ? ST_OUT : ST_DIV;
      ST_DIV:    if (dcnt_r == DCNT_W'(DIV_STEPS - 1)) state_nxt = ST_MAPEND;
      ST_MAPEND: state_nxt = (axis_r == 2'd2) ? ST_CINIT : ST_DIV;
      ST_CINIT:  state_nxt = ST_CITER;
      ST_CITER:  if (step_r == STEP_W'(CORDIC_STEPS - 1)) state_nxt = ST_CEND;
      ST_CEND:   state_nxt = (axis_r == 2'd2) ? ST_OUT : ST_CINIT;
      ST_OUT:    if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      min_r <= 16'sd265;
      max_r <= 16'sd402;
      refx_r <= '0; refy_r <= '0; refz_r <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        if (cfg_index == CFG_MIN_RAW) min_r <= cfg_data;
        else max_r <= cfg_data;
      end
      if (state_r == ST_OUT && out_free) begin
        ovalid_r <= 1'b1;
        if (!span_bad && act_r == ACT_CAPTURE) begin
          refx_r <= ux[14:0]; refy_r <= uy[14:0]; refz_r <= uz[14:0];
        end
      end else if (out_tready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: if (in_tvalid && in_tready) begin
        act_r <= in_tuser;
        raw_r[0] <= in_tdata[15:0];
        raw_r[1] <= in_tdata[31:16];
        raw_r[2] <= in_tdata[47:32];
        axis_r <= 2'd0;
        dcnt_r <= '0;
        rem_r <= '0;
      end
      ST_DIV: begin
        if (dcnt_r == '0) begin
          // load numerator; first bit shifted in on following cycles
          quo_r <= num_abs;
          neg_r <= num_s[MW-1];
          den_r <= MW'(18'(max_r) - 18'(min_r));
          rem_r <= '0;
          dcnt_r <= dcnt_r + 1'b1;
        end else begin
          if (!trial[MW]) rem_r <= trial[MW-1:0];
          else rem_r <= {rem_r[MW-2:0], quo_r[MW-1]};
          quo_r <= {quo_r[MW-2:0], !trial[MW]};
          dcnt_r <= dcnt_r + 1'b1;
        end
      end
      ST_MAPEND: begin
        map_r[axis_r] <= (neg_r ? -$signed(quo_r) : $signed(quo_r)) - MW'(90);
        axis_r <= (axis_r == 2'd2) ? 2'd0 : axis_r + 1'b1;
        dcnt_r <= '0;
      end
      ST_CINIT: begin
        step_r <= '0;
        if (pb < 0) begin
          cx_r <= -(CW'(pb) <<< 30); cy_r <= -(CW'(pa) <<< 30);
          cz_r <= (ZW+1)'(DEG180);
        end else begin
          cx_r <= CW'(pb) <<< 30; cy_r <= CW'(pa) <<< 30;
          cz_r <= '0;
        end
      end
      ST_CITER: begin
        step_r <= step_r + 1'b1;
        if (cy_r > 0) begin
          cx_r <= cx_r + dx; cy_r <= cy_r - dy;
          cz_r <= cz_r + (ZW+1)'(atan_lut(step_r));
        end else begin
          cx_r <= cx_r - dx; cy_r <= cy_r + dy;
          cz_r <= cz_r - (ZW+1)'(atan_lut(step_r));
        end
      end
      ST_CEND: begin
        if (pa == 0 && pb == 0) ang_r[axis_r] <= DEG180;
        else if (pa == 0) ang_r[axis_r] <= (pb > 0) ? DEG360 : DEG180;
        else if (pb == 0) ang_r[axis_r] <= (pa > 0) ? DEG90 : DEG270;
        else ang_r[axis_r] <= zw[ZW-1:0];
        axis_r <= (axis_r == 2'd2) ? 2'd0 : axis_r + 1'b1;
      end
      ST_OUT: if (out_free) begin
        if (span_bad) begin
          odata_r <= '0; ouser_r <= 1'b1;
        end else begin
          ouser_r <= 1'b0;
          if (act_r == ACT_CAPTURE) odata_r <= {uz, uy, ux};
          else odata_r <= {uz - {1'b0, refz_r}, uy - {1'b0, refy_r}, ux - {1'b0, refx_r}};
        end
      end
      default: ;
    endcase
  end

endmodule

### verif/tb_top.sv
// Testbench for the accelerometer tilt-angle unit with zero reference.
`timescale 1ns / 100ps

module tb_top;
  import atz_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // accel_x, accel_y, accel_z
  logic        in_tuser;   // action
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // angle_x, angle_y, angle_z
  logic        out_tuser;  // span_error
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [15:0] cfg_data;

  typedef struct packed {
    logic [15:0] ang_x;
    logic [15:0] ang_y;
    logic [15:0] ang_z;
    logic        span_err;
  } tilt_res_t;

  accel_tilt_angle_zeroed_unit u_top (.*);

  // predictor copy of registers and captured zero angles
  logic signed [15:0] span_lo, span_hi;
  logic [14:0] zero_x, zero_y, zero_z;
  tilt_res_t   tilt_q[$];
  int          err_cnt;
  int          cyc;
  int          send_idle_pct, recv_stall_pct;

  initial clk = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > 3000000) begin
      $display("FAIL accel_tilt_angle_zeroed_unit");
      $finish;
    end
  end

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  // atan2(-a,-b)+180 deg in 2^-20 degree
  function automatic longint tilt_acc(longint a, longint b);
    longint x, y, z, base, dx, dy;
    base = 0;
    if (a == 0 && b == 0) return 180 * 64'sd1048576;
    if (a == 0) return (b > 0 ? 360 : 180) * 64'sd1048576;
    if (b == 0) return (a > 0 ? 90 : 270) * 64'sd1048576;
    x = b * (64'sd1 <<< 30);
    y = a * (64'sd1 <<< 30);
    if (x < 0) begin
      x = -x;
      y = -y;
      base = 180 * 64'sd1048576;
    end
    z = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = shr_floor(y, i);
      dy = shr_floor(x, i);
      if (y > 0) begin
        x += dx; y -= dy; z += longint'(atan_lut(i[4:0]));
      end else begin
        x -= dx; y += dy; z -= longint'(atan_lut(i[4:0]));
      end
    end
    z += base;
    if (z < 0) z += 360 * 64'sd1048576;
    if (z > 360 * 64'sd1048576) z -= 360 * 64'sd1048576;
    return z;
  endfunction

  function automatic longint to_frac_units(longint acc);
    int sh;
    sh = ACC_BITS - ANGLE_FRAC_BITS;
    return (acc + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint map_axis(logic signed [15:0] raw);
    longint num, den;
    num = (longint'(raw) - longint'(span_lo)) * 180;
    den = longint'(span_hi) - longint'(span_lo);
    return num / den - 90;
  endfunction

  function automatic tilt_res_t predict_tilt(logic act, logic [47:0] smp);
    tilt_res_t r;
    longint mx, my, mz, ax, ay, az;
    if (span_hi <= span_lo) begin
      r = '0;
      r.span_err = 1'b1;
      return r;
    end
    mx = map_axis(smp[15:0]);
    my = map_axis(smp[31:16]);
    mz = map_axis(smp[47:32]);
    ax = to_frac_units(tilt_acc(my, mz));
    ay = to_frac_units(tilt_acc(mx, mz));
    az = to_frac_units(tilt_acc(my, mx));
    if (act == ACT_CAPTURE) begin
      zero_x = ax[14:0];
      zero_y = ay[14:0];
      zero_z = az[14:0];
    end else begin
      ax -= longint'(zero_x);
      ay -= longint'(zero_y);
      az -= longint'(zero_z);
    end
    r.ang_x = ax[15:0];
    r.ang_y = ay[15:0];
    r.ang_z = az[15:0];
    r.span_err = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %0d want %0d at cycle %0d", what,
             $signed(got), $signed(want), cyc);
    err_cnt++;
  endtask

  // result checker
  always @(posedge clk) begin
    tilt_res_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (tilt_q.size() == 0) begin
        report_mismatch("unexpected result", out_tdata[15:0], 16'd0);
      end else begin
        w = tilt_q.pop_front();
        if (out_tdata[15:0] !== w.ang_x) report_mismatch("angle_x", out_tdata[15:0], w.ang_x);
        if (out_tdata[31:16] !== w.ang_y) report_mismatch("angle_y", out_tdata[31:16], w.ang_y);
        if (out_tdata[47:32] !== w.ang_z) report_mismatch("angle_z", out_tdata[47:32], w.ang_z);
        if (out_tuser !== w.span_err)
          report_mismatch("span_error", {15'd0, out_tuser}, {15'd0, w.span_err});
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // tvalid stays high after an accept unless the sender idles or stops
  task automatic send_sample(logic act, logic [15:0] ax, logic [15:0] ay, logic [15:0] az);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {az, ay, ax};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tilt_q.push_back(predict_tilt(act, {az, ay, ax}));
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (tilt_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_MIN_RAW) span_lo = val;
    else span_hi = val;
    @(posedge clk);
  endtask

  task automatic set_span(logic [15:0] lo, logic [15:0] hi);
    wait_drained();
    write_reg(CFG_MIN_RAW, lo);
    write_reg(CFG_MAX_RAW, hi);
  endtask

  function automatic logic [15:0] raw_near(logic signed [15:0] lo, logic signed [15:0] hi);
    int w, v;
    if ($urandom_range(9) == 0) return 16'($urandom);
    w = int'(hi) - int'(lo);
    if (w < 1) w = 1;
    v = int'(lo) - w / 4 + int'($urandom_range(w + w / 2));
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  task automatic test_directed();
    logic [15:0] ctr;
    ctr = 16'(333);  // near mid-span at reset, maps to -1
    send_sample(ACT_CAPTURE, 16'd265, 16'd402, 16'd333);
    send_sample(1'b1, ctr, ctr, ctr);
    send_sample(1'b1, 16'd402, ctr, ctr);
    send_sample(1'b1, ctr, 16'd402, ctr);
    send_sample(1'b1, ctr, 16'd265, ctr);
    send_sample(1'b1, ctr, ctr, 16'd402);
    send_sample(1'b1, ctr, ctr, 16'd265);
    send_sample(1'b1, 16'h8000, 16'h7fff, 16'h8000);
    send_sample(1'b1, 16'h7fff, 16'h8000, 16'h7fff);
    send_sample(ACT_CAPTURE, 16'hffff, 16'h0000, 16'h5555);
    send_sample(1'b1, 16'haaaa, 16'h5555, 16'haaaa);
    set_span(16'h8000, 16'h7fff);
    send_sample(ACT_CAPTURE, 16'h8000, 16'h7fff, 16'h0000);
    send_sample(1'b1, 16'h7fff, 16'h8000, 16'hffff);
    // bad span: equal and inverted
    set_span(16'd100, 16'd100);
    send_sample(ACT_CAPTURE, 16'd5, 16'd6, 16'd7);
    set_span(16'h7fff, 16'h8000);
    send_sample(1'b1, 16'd5, 16'd6, 16'd7);
    set_span(16'd0, 16'd1);
    send_sample(1'b1, 16'd0, 16'd1, 16'd0);
  endtask

  task automatic test_random(int n, int idle, int stall);
    logic [15:0] lo, hi;
    wait_drained();
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      if (i % 60 == 0) begin
        case ($urandom_range(4))
          0: begin lo = 16'd265; hi = 16'd402; end
          1: begin lo = 16'h8000; hi = 16'h7fff; end
          2: begin lo = 16'($urandom); hi = 16'($urandom); end
          default: begin
            lo = 16'($urandom_range(40000) - 20000);
            hi = lo + 16'($urandom_range(3000, 1));
          end
        endcase
        set_span(lo, hi);
      end
      send_sample($urandom_range(3) != 0, raw_near(span_lo, span_hi),
                  raw_near(span_lo, span_hi), raw_near(span_lo, span_hi));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_MIN_RAW;
    cfg_data = '0;
    cyc = 0;
    err_cnt = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    span_lo = 16'sd265;
    span_hi = 16'sd402;
    zero_x = '0; zero_y = '0; zero_z = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(300, 0, 0);
    test_random(300, 79, 0);
    test_random(300, 0, 79);
    test_random(300, 31, 31);
    wait_drained();
    if (err_cnt == 0) $display("PASS accel_tilt_angle_zeroed_unit");
    else $display("FAIL accel_tilt_angle_zeroed_unit");
    $finish;
  end

endmodule
